### rtl/core/slrs_pkg.sv
// Shared types and constants for the sample log ring store.
// Depends on nothing; imported by the top level, the controller and the datapath.
package slrs_pkg;

    localparam int DEPTH_DEF        = 2048;
    localparam int PAGE_ENTRIES_DEF = 64;
    localparam int SAMPLE_W         = 16;
    localparam int PAGE_W           = 5;
    localparam int IN_DATA_W        = 40;

    typedef enum logic [1:0] {
        MODE_SAVE  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_ERASE = 2'd2,
        MODE_INFO  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_ERASED = 2'd1,
        KIND_INFO   = 2'd2
    } t_kind;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic save;
        logic erase;
        logic load_page;
        logic reduce;
        logic addr_load;
        logic rd_issue;
        logic rd_last;
        logic reply_load;
        logic reply_info;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic base_wrap;
        logic issue_ok;
        logic s1_busy;
        logic out_free;
    } t_stat;

endpackage

### rtl/core/sample_log_ring_store.sv
// Top level of the sample log ring store: stream ports around the controller
// and the datapath. Depends on slrs_pkg, slrs_ctrl, slrs_dp, slrs_ram.

// Logger for paired conductivity and temperature samples in a ring of DEPTH
// 32-bit entries held in one simple dual-port RAM. A request carries its mode
// in tuser. A save gives no reply: it fills entries in order, and once the
// store is full it replaces the entry at the oldest pointer and advances that
// pointer with wrap. A page read gives PAGE_ENTRIES replies from absolute index
// page*PAGE_ENTRIES upwards (wrapping past the store end), tlast on the final
// one; after a setup that folds DEPTH off the page start while the page lies
// past a small store (never at the default sizes) and loads the read address,
// it streams one entry per cycle, paced by the single RAM read port and by
// tready. Entries at or above the fill count read as zero,
// so an erase costs no clearing pass: it drops the count and the pointer and
// gives one acknowledgement. An info request gives one reply with the fill
// count and oldest pointer. One request is worked on at a time; the next is
// taken once the read stage has drained, while the last reply may still wait
// in the output register.
module sample_log_ring_store #(
    parameter int DEPTH        = slrs_pkg::DEPTH_DEF,
    parameter int PAGE_ENTRIES = slrs_pkg::PAGE_ENTRIES_DEF,
    localparam int IW          = $clog2(DEPTH),
    localparam int CW          = $clog2(DEPTH + 1),
    localparam int OUT_W       = 2 * slrs_pkg::SAMPLE_W + 2 * IW + CW,
    localparam int OUT_DATA_W  = ((OUT_W + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Request side
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // tdata: cond_sample[15:0], temp_sample[31:16], page[36:32], zero fill
    input  logic [slrs_pkg::IN_DATA_W-1:0] i_s_tdata,
    // tuser: mode[1:0]
    input  logic [1:0]                     i_s_tuser,
    // Reply side
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // tdata: out_cond, out_temp, entry_index, stored_count, oldest_index, zero fill
    output logic [OUT_DATA_W-1:0]          o_m_tdata,
    // tuser: reply_kind[1:0]
    output logic [1:0]                     o_m_tuser,
    output logic                           o_m_tlast
);
    import slrs_pkg::*;

    t_cmd                cmd;
    t_stat               stat;
    t_kind               dp_kind;
    logic [SAMPLE_W-1:0] dp_cond;
    logic [SAMPLE_W-1:0] dp_temp;
    logic [IW-1:0]       dp_index;
    logic [CW-1:0]       dp_count;
    logic [IW-1:0]       dp_oldest;

    // Decode requests and sequence the work
    slrs_ctrl #(
        .PAGE_ENTRIES (PAGE_ENTRIES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_mode  (t_mode'(i_s_tuser)),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Hold the store, the count and pointer, and the reply register
    slrs_dp #(
        .DEPTH        (DEPTH),
        .PAGE_ENTRIES (PAGE_ENTRIES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .i_cond   (i_s_tdata[SAMPLE_W-1:0]),
        .i_temp   (i_s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .i_page   (i_s_tdata[2*SAMPLE_W+PAGE_W-1:2*SAMPLE_W]),
        .i_ready  (i_m_tready),
        .o_valid  (o_m_tvalid),
        .o_kind   (dp_kind),
        .o_cond   (dp_cond),
        .o_temp   (dp_temp),
        .o_index  (dp_index),
        .o_count  (dp_count),
        .o_oldest (dp_oldest),
        .o_last   (o_m_tlast)
    );

    // Pack the reply, lowest field first, zero fill to whole bytes
    assign o_m_tdata = OUT_DATA_W'({dp_oldest, dp_count, dp_index, dp_temp, dp_cond});
    assign o_m_tuser = dp_kind;

endmodule

### rtl/core/slrs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module slrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/slrs_ctrl.sv
// Controller state machine of the sample log ring store: decodes requests,
// sequences page reads and replies. Depends on slrs_pkg.
module slrs_ctrl #(
    parameter int PAGE_ENTRIES = slrs_pkg::PAGE_ENTRIES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  slrs_pkg::t_mode i_mode,
    input  slrs_pkg::t_stat i_stat,
    output slrs_pkg::t_cmd  o_cmd
);
    import slrs_pkg::*;

    localparam int KW = (PAGE_ENTRIES > 1) ? $clog2(PAGE_ENTRIES) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_STREAM,
        ST_REPLY
    } t_state;

    t_state        r_state;
    logic [KW-1:0] r_k;
    logic          r_info;
    logic          accept;
    logic          k_last;

    assign o_ready = (r_state == ST_IDLE) && !i_stat.s1_busy;
    assign accept  = i_valid && o_ready;
    assign k_last  = (r_k == KW'(PAGE_ENTRIES - 1));

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_mode)
                        MODE_SAVE:  o_cmd.save      = 1'b1;
                        MODE_READ:  o_cmd.load_page = 1'b1;
                        MODE_ERASE: o_cmd.erase     = 1'b1;
                        MODE_INFO:  ;
                        default:    ;
                    endcase
                end
            end
            ST_REDUCE: begin
                o_cmd.reduce    = i_stat.base_wrap;
                o_cmd.addr_load = !i_stat.base_wrap;
            end
            ST_STREAM: begin
                o_cmd.rd_issue = i_stat.issue_ok;
                o_cmd.rd_last  = k_last;
            end
            ST_REPLY: begin
                o_cmd.reply_load = i_stat.out_free;
                o_cmd.reply_info = r_info;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_info  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        unique case (i_mode)
                            MODE_SAVE:  r_state <= ST_IDLE;
                            MODE_READ:  r_state <= ST_REDUCE;
                            MODE_ERASE: begin
                                r_state <= ST_REPLY;
                                r_info  <= 1'b0;
                            end
                            MODE_INFO: begin
                                r_state <= ST_REPLY;
                                r_info  <= 1'b1;
                            end
                            default:    r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_REDUCE: begin
                    if (!i_stat.base_wrap) begin
                        r_state <= ST_STREAM;
                        r_k     <= '0;
                    end
                end
                ST_STREAM: begin
                    if (i_stat.issue_ok) begin
                        if (k_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_k <= r_k + KW'(1);
                        end
                    end
                end
                ST_REPLY: begin
                    if (i_stat.out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/slrs_dp.sv
// Datapath of the sample log ring store: fill count, overwrite pointer, page
// address, sample RAM, read stage and output register. Depends on slrs_pkg, slrs_ram.
module slrs_dp #(
    parameter int DEPTH        = slrs_pkg::DEPTH_DEF,
    parameter int PAGE_ENTRIES = slrs_pkg::PAGE_ENTRIES_DEF,
    localparam int IW          = $clog2(DEPTH),
    localparam int CW          = $clog2(DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  slrs_pkg::t_cmd                i_cmd,
    output slrs_pkg::t_stat               o_stat,
    input  logic [slrs_pkg::SAMPLE_W-1:0] i_cond,
    input  logic [slrs_pkg::SAMPLE_W-1:0] i_temp,
    input  logic [slrs_pkg::PAGE_W-1:0]   i_page,
    input  logic                          i_ready,
    output logic                          o_valid,
    output slrs_pkg::t_kind               o_kind,
    output logic [slrs_pkg::SAMPLE_W-1:0] o_cond,
    output logic [slrs_pkg::SAMPLE_W-1:0] o_temp,
    output logic [IW-1:0]                 o_index,
    output logic [CW-1:0]                 o_count,
    output logic [IW-1:0]                 o_oldest,
    output logic                          o_last
);
    import slrs_pkg::*;

    localparam int RAW_W = PAGE_W + $clog2(PAGE_ENTRIES + 1);
    localparam int WORD_W = 2 * SAMPLE_W;

    logic [CW-1:0]    r_count;
    logic [IW-1:0]    r_ptr;
    logic [RAW_W-1:0] r_base;
    logic [IW-1:0]    r_addr;
    logic             r_s1_v;
    logic             r_s1_live;
    logic             r_s1_last;
    logic [IW-1:0]    r_s1_idx;
    logic             r_o_valid;
    t_kind            r_o_kind;
    logic [SAMPLE_W-1:0] r_o_cond;
    logic [SAMPLE_W-1:0] r_o_temp;
    logic [IW-1:0]    r_o_index;
    logic [CW-1:0]    r_o_count;
    logic [IW-1:0]    r_o_oldest;
    logic             r_o_last;

    logic             not_full;
    logic [IW-1:0]    wr_addr;
    logic [WORD_W-1:0] rd_data;
    logic             out_free;
    logic             move_s1;
    logic [IW-1:0]    n_addr;
    logic [IW-1:0]    n_ptr;

    assign not_full = (32'(r_count) < DEPTH);
    assign wr_addr  = not_full ? IW'(r_count) : r_ptr;
    assign out_free = !r_o_valid || i_ready;
    assign move_s1  = r_s1_v && out_free;
    assign n_addr   = (r_addr == IW'(DEPTH - 1)) ? '0 : r_addr + IW'(1);
    assign n_ptr    = (r_ptr == IW'(DEPTH - 1)) ? '0 : r_ptr + IW'(1);

    assign o_stat.base_wrap = (32'(r_base) >= DEPTH);
    assign o_stat.issue_ok  = !r_s1_v || move_s1;
    assign o_stat.s1_busy   = r_s1_v;
    assign o_stat.out_free  = out_free;

    slrs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.save),
        .i_wr_addr (wr_addr),
        .i_wr_data ({i_temp, i_cond}),
        .i_rd_en   (i_cmd.rd_issue),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

    // Fill count and overwrite pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ptr   <= '0;
        end else if (i_cmd.erase) begin
            r_count <= '0;
            r_ptr   <= '0;
        end else if (i_cmd.save) begin
            if (not_full) begin
                r_count <= r_count + CW'(1);
            end else begin
                r_ptr <= n_ptr;
            end
        end
    end

    // Page start, folded into the store, then a running read address
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_page) begin
            r_base <= RAW_W'(i_page) * RAW_W'(PAGE_ENTRIES);
        end else if (i_cmd.reduce) begin
            r_base <= r_base - RAW_W'(DEPTH);
        end
        if (i_cmd.addr_load) begin
            r_addr <= IW'(32'(r_base));
        end else if (i_cmd.rd_issue) begin
            r_addr <= n_addr;
        end
    end

    // Read stage alongside the RAM output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (i_cmd.rd_issue) begin
            r_s1_v <= 1'b1;
        end else if (move_s1) begin
            r_s1_v <= 1'b0;
        end
        if (i_cmd.rd_issue) begin
            r_s1_idx  <= r_addr;
            r_s1_live <= (32'(r_addr) < 32'(r_count));
            r_s1_last <= i_cmd.rd_last;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (move_s1 || i_cmd.reply_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
        if (move_s1) begin
            r_o_kind   <= KIND_DATA;
            r_o_cond   <= r_s1_live ? rd_data[SAMPLE_W-1:0] : '0;
            r_o_temp   <= r_s1_live ? rd_data[WORD_W-1:SAMPLE_W] : '0;
            r_o_index  <= r_s1_idx;
            r_o_count  <= '0;
            r_o_oldest <= '0;
            r_o_last   <= r_s1_last;
        end else if (i_cmd.reply_load) begin
            r_o_kind   <= i_cmd.reply_info ? KIND_INFO : KIND_ERASED;
            r_o_cond   <= '0;
            r_o_temp   <= '0;
            r_o_index  <= '0;
            r_o_count  <= i_cmd.reply_info ? r_count : '0;
            r_o_oldest <= i_cmd.reply_info ? r_ptr : '0;
            r_o_last   <= 1'b1;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_kind   = r_o_kind;
    assign o_cond   = r_o_cond;
    assign o_temp   = r_o_temp;
    assign o_index  = r_o_index;
    assign o_count  = r_o_count;
    assign o_oldest = r_o_oldest;
    assign o_last   = r_o_last;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= DEPTH)
        else $error("fill count beyond store depth");

    a_ptr_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ptr != '0) |-> (32'(r_count) == DEPTH))
        else $error("overwrite pointer moved before store full");

    a_issue_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_issue |-> (!r_s1_v || move_s1))
        else $error("read issued into an occupied stage");

    a_erase_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.erase |=> (r_count == '0 && r_ptr == '0))
        else $error("erase left count or pointer set");
`endif

endmodule
